### sv/cls_pkg.sv
// Shared types and constants of the Cramer's-rule solver.
package cls_pkg;

    localparam int COEF_W = 32;
    localparam int CFG_W  = 3;
    localparam int IDX_W  = 2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PERM_INIT,
        S_PERM_CHECK,
        S_READ,
        S_MUL_SET,
        S_MUL,
        S_ACC,
        S_PERM_NEXT,
        S_DET_DONE,
        S_COL_START,
        S_DIV_INIT,
        S_DIV,
        S_DIV_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic perm_init;
        logic perm_start;
        logic mul_set;
        logic mul_step;
        logic row_next;
        logic acc;
        logic perm_next;
        logic save_deta;
        logic cols_start;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic out_sing;
        logic col_next;
    } t_cmd;

    typedef struct packed {
        logic load_last;
        logic perm_ok;
        logic perm_wrap;
        logic row_last;
        logic limb_last;
        logic div_last;
        logic use_b;
        logic singular;
        logic col_last;
    } t_stat;

endpackage

### sv/cls_ifs.sv
// Stream interfaces: coefficient input and result output.
interface cls_coef_if;
    logic                                valid;
    logic                                ready;
    logic signed [cls_pkg::COEF_W-1:0]   coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

interface cls_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [cls_pkg::COEF_W-1:0]   solution;
    logic        [cls_pkg::IDX_W-1:0]    unknown_index;
    logic                                last_result;
    logic                                singular;
    logic                                saturated;

    modport source (output valid, output solution, output unknown_index, output last_result,
                    output singular, output saturated, input ready);
    modport sink   (input valid, input solution, input unknown_index, input last_result,
                    input singular, input saturated, output ready);
endinterface

### sv/cls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/cls_datapath.sv
// Datapath: coefficient stores, permutation walk, limb-serial multiply, divider.
module cls_datapath #(
    parameter int MAX_N = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cls_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [cls_pkg::COEF_W-1:0] i_coef,
    input  cls_pkg::t_cmd                     i_cmd,
    output cls_pkg::t_stat                    o_stat,
    output logic signed [cls_pkg::COEF_W-1:0] o_solution,
    output logic [cls_pkg::IDX_W-1:0]         o_unknown_index,
    output logic                              o_last_result,
    output logic                              o_singular,
    output logic                              o_saturated
);
    localparam int LIMBS = MAX_N + 2;
    localparam int W     = 32 * LIMBS;
    localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW    = (MAX_N * MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
    localparam int LW    = $clog2(LIMBS);
    localparam int BW    = $clog2(W);
    localparam int CW    = cls_pkg::CFG_W;

    logic [CW-1:0]  r_size;
    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  nm1;
    logic [IW-1:0]  nm1_i;

    logic [IW-1:0]  r_lrow, r_lcol;
    logic           r_lrhs;

    logic [IW-1:0]  r_dig [MAX_N];
    logic [IW-1:0]  n_dig [MAX_N];
    logic           perm_ok, perm_par, perm_carry;
    logic [IW-1:0]  r_prow;
    logic [IW-1:0]  cur_dig;

    logic [AW-1:0]  mat_waddr, mat_raddr;
    logic [31:0]    mat_rd, rhs_rd, ent;

    logic           r_neg;
    logic [31:0]    r_mag;
    logic [W-1:0]   r_term;
    logic [31:0]    r_carry;
    logic [LW-1:0]  r_limb;
    logic [63:0]    prod;
    logic [W-1:0]   r_acc;
    logic [W-1:0]   r_deta;
    logic           r_sing;

    logic [IW-1:0]  r_dcol;
    logic           r_use_b;
    logic [IW+1:0]  col_x;

    logic [W-1:0]   acc_mag, deta_mag;
    logic [W-1:0]   r_num, r_den, r_rem, r_q;
    logic [W-1:0]   rem_sh;
    logic           r_qneg;
    logic [BW-1:0]  r_bit;
    logic           fits;
    logic [31:0]    lim, q0;

    logic signed [cls_pkg::COEF_W-1:0] r_sol;
    logic           r_sat;

    always_comb begin
        if (r_size == '0) begin
            n_eff = CW'(1);
        end else if (r_size > CW'(MAX_N)) begin
            n_eff = CW'(MAX_N);
        end else begin
            n_eff = r_size;
        end
        nm1   = n_eff - CW'(1);
        nm1_i = nm1[IW-1:0];
    end

    // load sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CW'(4);
            r_lrow <= '0;
            r_lcol <= '0;
            r_lrhs <= 1'b0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
            r_lrow <= '0;
            r_lcol <= '0;
            r_lrhs <= 1'b0;
        end else if (i_cmd.load_wr) begin
            if (!r_lrhs) begin
                if (r_lcol == nm1_i) begin
                    r_lcol <= '0;
                    if (r_lrow == nm1_i) begin
                        r_lrow <= '0;
                        r_lrhs <= 1'b1;
                    end else begin
                        r_lrow <= r_lrow + 1'b1;
                    end
                end else begin
                    r_lcol <= r_lcol + 1'b1;
                end
            end else if (r_lrow == nm1_i) begin
                r_lrow <= '0;
                r_lrhs <= 1'b0;
            end else begin
                r_lrow <= r_lrow + 1'b1;
            end
        end
    end

    assign cur_dig   = r_dig[r_prow];
    assign mat_waddr = AW'(r_lrow) * AW'(MAX_N) + AW'(r_lcol);
    assign mat_raddr = AW'(r_prow) * AW'(MAX_N) + AW'(cur_dig);

    cls_ram #(.WIDTH(32), .DEPTH(MAX_N * MAX_N)) u_mat (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && !r_lrhs),
        .i_waddr (mat_waddr),
        .i_wdata (i_coef),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rd)
    );

    cls_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_rhs (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && r_lrhs),
        .i_waddr (r_lrow),
        .i_wdata (i_coef),
        .i_raddr (r_prow),
        .o_rdata (rhs_rd)
    );

    // permutation check, parity and base-n increment of the column tuple
    always_comb begin
        perm_ok  = 1'b1;
        perm_par = 1'b0;
        for (int a = 0; a < MAX_N; a++) begin
            for (int b = a + 1; b < MAX_N; b++) begin
                if (CW'(b) < n_eff) begin
                    if (r_dig[a] == r_dig[b]) perm_ok = 1'b0;
                    if (r_dig[a] > r_dig[b]) perm_par = ~perm_par;
                end
            end
        end
        perm_carry = 1'b1;
        for (int r = MAX_N - 1; r >= 0; r--) begin
            n_dig[r] = r_dig[r];
            if (CW'(r) < n_eff && perm_carry) begin
                if (r_dig[r] == nm1_i) begin
                    n_dig[r] = '0;
                end else begin
                    n_dig[r]   = r_dig[r] + 1'b1;
                    perm_carry = 1'b0;
                end
            end
        end
    end

    assign ent  = (r_use_b && cur_dig == r_dcol) ? rhs_rd : mat_rd;
    assign prod = 64'(r_term[31:0]) * 64'(r_mag) + 64'(r_carry);

    always_ff @(posedge i_clk) begin
        if (i_cmd.perm_init) begin
            for (int r = 0; r < MAX_N; r++) r_dig[r] <= '0;
            r_acc <= '0;
        end else if (i_cmd.perm_next) begin
            for (int r = 0; r < MAX_N; r++) r_dig[r] <= n_dig[r];
        end
        if (i_cmd.perm_start) begin
            r_term <= W'(1);
            r_neg  <= perm_par;
            r_prow <= '0;
        end
        if (i_cmd.mul_set) begin
            r_neg   <= r_neg ^ ent[31];
            r_mag   <= ent[31] ? (32'd0 - ent) : ent;
            r_carry <= '0;
            r_limb  <= '0;
        end
        if (i_cmd.mul_step) begin
            r_term  <= {prod[31:0], r_term[W-1:32]};
            r_carry <= prod[63:32];
            r_limb  <= r_limb + 1'b1;
        end
        if (i_cmd.row_next) begin
            r_prow <= r_prow + 1'b1;
        end
        if (i_cmd.acc) begin
            r_acc <= r_neg ? (r_acc - r_term) : (r_acc + r_term);
        end
        if (i_cmd.save_deta) begin
            r_deta <= r_acc;
            r_sing <= (r_acc == '0);
        end
    end

    // unknown-column bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_b <= 1'b0;
            r_dcol  <= '0;
        end else if (i_cmd.load_wr) begin
            r_use_b <= 1'b0;
        end else if (i_cmd.cols_start) begin
            r_use_b <= 1'b1;
            r_dcol  <= '0;
        end else if (i_cmd.col_next) begin
            r_dcol <= r_dcol + 1'b1;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign acc_mag  = r_acc[W-1] ? (W'(0) - r_acc) : r_acc;
    assign deta_mag = r_deta[W-1] ? (W'(0) - r_deta) : r_deta;
    assign rem_sh   = {r_rem[W-2:0], r_num[W-1]};
    assign fits     = (r_q[W-1:32] == '0) && (r_q[31:0] <= lim);
    assign lim      = r_qneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign q0       = fits ? r_q[31:0] : lim;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_num  <= {acc_mag[W-17:0], 16'h0000};
            r_den  <= deta_mag;
            r_qneg <= r_acc[W-1] ^ r_deta[W-1];
            r_rem  <= '0;
            r_q    <= '0;
            r_bit  <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[W-2:0], 1'b0};
            r_bit <= r_bit + 1'b1;
            if (rem_sh >= r_den) begin
                r_rem <= rem_sh - r_den;
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_fin) begin
            r_sol <= r_qneg ? (32'd0 - q0) : q0;
            r_sat <= !fits;
        end else if (i_cmd.out_sing) begin
            r_sol <= '0;
            r_sat <= 1'b0;
        end
    end

    assign col_x = (IW + 2)'(r_dcol);

    assign o_stat.load_last = r_lrhs && (r_lrow == nm1_i);
    assign o_stat.perm_ok   = perm_ok;
    assign o_stat.perm_wrap = perm_carry;
    assign o_stat.row_last  = (r_prow == nm1_i);
    assign o_stat.limb_last = (r_limb == LW'(LIMBS - 1));
    assign o_stat.div_last  = (r_bit == BW'(W - 1));
    assign o_stat.use_b     = r_use_b;
    assign o_stat.singular  = r_sing;
    assign o_stat.col_last  = (r_dcol == nm1_i);

    assign o_solution      = r_sol;
    assign o_unknown_index = col_x[1:0];
    assign o_last_result   = (r_dcol == nm1_i);
    assign o_singular      = r_sing;
    assign o_saturated     = r_sat;
endmodule

### sv/cls_ctrl.sv
// Controller state machine sequencing load, determinants, division and output.
module cls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  cls_pkg::t_stat i_stat,
    output cls_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);
    cls_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cls_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            cls_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_stat.load_last) n_state = cls_pkg::S_PERM_INIT;
                end
            end
            cls_pkg::S_PERM_INIT: begin
                o_cmd.perm_init = 1'b1;
                n_state = cls_pkg::S_PERM_CHECK;
            end
            cls_pkg::S_PERM_CHECK: begin
                if (i_stat.perm_ok) begin
                    o_cmd.perm_start = 1'b1;
                    n_state = cls_pkg::S_READ;
                end else begin
                    n_state = cls_pkg::S_PERM_NEXT;
                end
            end
            cls_pkg::S_READ: begin
                n_state = cls_pkg::S_MUL_SET;
            end
            cls_pkg::S_MUL_SET: begin
                o_cmd.mul_set = 1'b1;
                n_state = cls_pkg::S_MUL;
            end
            cls_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.limb_last) begin
                    o_cmd.row_next = 1'b1;
                    n_state = i_stat.row_last ? cls_pkg::S_ACC : cls_pkg::S_READ;
                end
            end
            cls_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = cls_pkg::S_PERM_NEXT;
            end
            cls_pkg::S_PERM_NEXT: begin
                o_cmd.perm_next = 1'b1;
                n_state = i_stat.perm_wrap ? cls_pkg::S_DET_DONE : cls_pkg::S_PERM_CHECK;
            end
            cls_pkg::S_DET_DONE: begin
                if (i_stat.use_b) begin
                    n_state = cls_pkg::S_DIV_INIT;
                end else begin
                    o_cmd.save_deta  = 1'b1;
                    o_cmd.cols_start = 1'b1;
                    n_state = cls_pkg::S_COL_START;
                end
            end
            cls_pkg::S_COL_START: begin
                if (i_stat.singular) begin
                    o_cmd.out_sing = 1'b1;
                    n_state = cls_pkg::S_OUT;
                end else begin
                    n_state = cls_pkg::S_PERM_INIT;
                end
            end
            cls_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state = cls_pkg::S_DIV;
            end
            cls_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = cls_pkg::S_DIV_FIN;
            end
            cls_pkg::S_DIV_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state = cls_pkg::S_OUT;
            end
            cls_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.col_last) begin
                        n_state = cls_pkg::S_LOAD;
                    end else begin
                        o_cmd.col_next = 1'b1;
                        n_state = cls_pkg::S_COL_START;
                    end
                end
            end
            default: n_state = cls_pkg::S_LOAD;
        endcase
    end
endmodule

### sv/cramer_linear_solver.sv
// Top level of the Cramer's-rule linear system solver.
//
// i_coef takes signed Q16.16 coefficients, one per transfer: the n*n entries of
// A row-major, then the n entries of b. i_cfg_we/i_cfg_data set n (0 acts as 1,
// above MAX_N acts as MAX_N) and restart the load; write only while idle.
// After the last b transfer the block computes det(A), then for each unknown i
// det(A_i) and the quotient, and presents x_i on o_result, indices 0..n-1, with
// last_result on the final one. A zero det(A) gives zeros with singular set.
// A determinant walks all n^n column tuples and skips those that are no
// permutation; each of the n! permutations goes through the limb-serial
// 32x32 multiplier, and each quotient goes through the bit-serial divider.
// One result is held until taken; a stalled receiver stops the sequencer and
// no coefficient is taken until the last result transfers.
// Reset (synchronous, active low) sets n to 4 and empties the load; stores
// keep their contents.
module cramer_linear_solver #(
    parameter int MAX_N = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cls_pkg::CFG_W-1:0] i_cfg_data,
    cls_coef_if.sink                  i_coef,
    cls_result_if.source              o_result
);
    cls_pkg::t_cmd  cmd;
    cls_pkg::t_stat stat;

    cls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_coef.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (i_coef.ready),
        .o_out_valid (o_result.valid)
    );

    cls_datapath #(.MAX_N(MAX_N)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_coef          (i_coef.coefficient),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_solution      (o_result.solution),
        .o_unknown_index (o_result.unknown_index),
        .o_last_result   (o_result.last_result),
        .o_singular      (o_result.singular),
        .o_saturated     (o_result.saturated)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_coef.ready && o_result.valid))
        else $error("input taken while a result is pending");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.singular) |->
            (o_result.solution == '0 && !o_result.saturated))
        else $error("singular result is not zero");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && o_result.last_result) |=> i_coef.ready)
        else $error("load not reopened after last result");

    a_load_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_coef.valid && i_coef.ready && !i_cfg_we) |=> !o_result.valid)
        else $error("result appeared right after a coefficient");
endmodule
